FILE: sv/shp3_pkg.sv
// Shared types, widths and register codes of the 3x3 RGB sharpening stream.
package shp3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WCFG_W     = COL_W + 1;
	localparam int ROW_W      = 16;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(1024);
	localparam logic [ROW_W-1:0]  HEIGHT_RST = ROW_W'(768);

	typedef logic [PIX_W-1:0] pix_t;
	// one window column, indexed by row: [0] two rows up, [2] current row
	typedef pix_t [2:0] col_t;
	// window, indexed by column: [0] oldest, [2] newest
	typedef col_t [2:0] win_t;
	typedef logic [1:0] widx_t;

	// one pixel on its way from the line buffer to the window
	typedef struct packed {
		pix_t              upper;
		pix_t              middle;
		pix_t              px;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              x_left;
		logic              x_right;
		logic              y_up;
		logic              y_down;
		logic              col_is1;
		logic              row_is1;
	} s1_t;

endpackage

FILE: sv/sharpen_3x3_rgb_stream.sv
// A pixel's first result is registered in stage one, in the window and in the output register.
// Throughput: one input beat per cycle while the result sequencer is free; a pixel that
//   causes k results holds it until its last result leaves, so row ends and the last row stall.
// Results of one pixel follow on consecutive cycles while the output is taken.
// Reset (arst_n low, asynchronous): counters, window and valid flags clear, width 1024,
//   height 768; the line buffer is not cleared and holds nothing until written.
module sharpen_3x3_rgb_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [shp3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [shp3_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [shp3_pkg::CH_W-1:0]         in_red,
	input  logic [shp3_pkg::CH_W-1:0]         in_green,
	input  logic [shp3_pkg::CH_W-1:0]         in_blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [shp3_pkg::CH_W-1:0]         out_red,
	output logic [shp3_pkg::CH_W-1:0]         out_green,
	output logic [shp3_pkg::CH_W-1:0]         out_blue,
	output logic [shp3_pkg::COL_W-1:0]        out_column,
	output logic [shp3_pkg::ROW_W-1:0]        out_row,
	output logic                              last_of_run,
	output logic                              frame_done
);

	// Stage one: clamp the raster position, read both line rows from one
	// 48-bit wide buffer and register the pixel. The buffer entry is rewritten
	// (row r-1 moves up, the new pixel becomes row r-1) when the pixel
	// advances into the window.
	logic           v_s1;
	logic           take;
	shp3_pkg::s1_t  item_s1;

	shp3_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.v_s1         (v_s1),
		.item_s1      (item_s1),
		.take         (take)
	);

	// Stage two: shift the new column into the window, then step through the
	// up to four finished pixels in raster order, one beat into the output register
	// per cycle while the output is free. The next pixel enters as the last result leaves.
	shp3_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.item_s1     (item_s1),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_column  (out_column),
		.out_row     (out_row),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

FILE: sv/shp3_front.sv
// Configuration registers, raster counters, line buffer and the first pipeline stage.
module shp3_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [shp3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [shp3_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [shp3_pkg::CH_W-1:0]         in_red,
	input  logic [shp3_pkg::CH_W-1:0]         in_green,
	input  logic [shp3_pkg::CH_W-1:0]         in_blue,
	output logic                              v_s1,
	output shp3_pkg::s1_t                     item_s1,
	input  logic                              take
);

	logic [shp3_pkg::WCFG_W-1:0]  width_q, w_eff;
	logic [shp3_pkg::ROW_W-1:0]   height_q, hm1;
	logic [shp3_pkg::COL_W-1:0]   wm1, col_q, cu;
	logic [shp3_pkg::ROW_W-1:0]   row_q, ru;
	logic                         acc;
	shp3_pkg::pix_t               pix;

	logic [2*shp3_pkg::PIX_W-1:0] line_mem [shp3_pkg::MAX_WIDTH];
	logic [2*shp3_pkg::PIX_W-1:0] rd_s1, fwd_data_s1;
	logic                         fwd_s1;
	shp3_pkg::pix_t               px_s1;
	logic [shp3_pkg::COL_W-1:0]   col_s1;
	logic [shp3_pkg::ROW_W-1:0]   row_s1;
	logic                         xl_s1, xr_s1, yu_s1, yd_s1, c1_s1, r1_s1;

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) begin
			w_eff = shp3_pkg::WCFG_W'(1);
		end else if (width_q > shp3_pkg::WCFG_W'(shp3_pkg::MAX_WIDTH)) begin
			w_eff = shp3_pkg::WCFG_W'(shp3_pkg::MAX_WIDTH);
		end
		wm1 = shp3_pkg::COL_W'(w_eff - shp3_pkg::WCFG_W'(1));
		hm1 = (height_q == '0) ? '0 : height_q - shp3_pkg::ROW_W'(1);
		cu  = (col_q < wm1) ? col_q : wm1;
		ru  = (row_q < hm1) ? row_q : hm1;
	end

	assign pix      = {in_red, in_green, in_blue};
	assign in_ready = !v_s1 || take;
	assign acc      = in_valid && in_ready;

	always_comb begin
		item_s1 = '0;
		{item_s1.upper, item_s1.middle} = fwd_s1 ? fwd_data_s1 : rd_s1;
		item_s1.px      = px_s1;
		item_s1.col     = col_s1;
		item_s1.row     = row_s1;
		item_s1.x_left  = xl_s1;
		item_s1.x_right = xr_s1;
		item_s1.y_up    = yu_s1;
		item_s1.y_down  = yd_s1;
		item_s1.col_is1 = c1_s1;
		item_s1.row_is1 = r1_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= shp3_pkg::WIDTH_RST;
			height_q <= shp3_pkg::HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					shp3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[shp3_pkg::WCFG_W-1:0];
					shp3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[shp3_pkg::ROW_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				v_s1 <= 1'b1;
				if (cu == wm1) begin
					col_q <= '0;
					row_q <= (ru == hm1) ? '0 : ru + shp3_pkg::ROW_W'(1);
				end else begin
					col_q <= cu + shp3_pkg::COL_W'(1);
					row_q <= ru;
				end
			end else if (take) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// stage payload; forward the pending write when a one-pixel row rereads it
	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1       <= pix;
			col_s1      <= cu;
			row_s1      <= ru;
			xl_s1       <= (cu != '0);
			xr_s1       <= (cu == wm1);
			yu_s1       <= (ru != '0);
			yd_s1       <= (ru == hm1);
			c1_s1       <= (cu == shp3_pkg::COL_W'(1));
			r1_s1       <= (ru == shp3_pkg::ROW_W'(1));
			fwd_s1      <= take && (col_s1 == cu);
			fwd_data_s1 <= {item_s1.middle, item_s1.px};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			line_mem[item_s1.col] <= {item_s1.middle, item_s1.px};
		end
		if (acc) begin
			rd_s1 <= line_mem[cu];
		end
	end

endmodule

FILE: sv/shp3_kernel.sv
// Five-tap sharpening kernel with clipping for the three channels of one pixel.
module shp3_kernel (
	input  shp3_pkg::win_t             win,
	input  shp3_pkg::widx_t            kx,
	input  shp3_pkg::widx_t            kl,
	input  shp3_pkg::widx_t            ky,
	input  shp3_pkg::widx_t            ku,
	output logic [shp3_pkg::CH_W-1:0]  red,
	output logic [shp3_pkg::CH_W-1:0]  green,
	output logic [shp3_pkg::CH_W-1:0]  blue
);

	shp3_pkg::pix_t pc, pu, pd, pl, pr;

	function automatic logic [shp3_pkg::CH_W-1:0] sharpen(
		input logic [shp3_pkg::CH_W-1:0] c,
		input logic [shp3_pkg::CH_W-1:0] u,
		input logic [shp3_pkg::CH_W-1:0] d,
		input logic [shp3_pkg::CH_W-1:0] l,
		input logic [shp3_pkg::CH_W-1:0] r
	);
		logic signed [shp3_pkg::CH_W+3:0] s;
		logic [shp3_pkg::CH_W-1:0]        res;
		s = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
			- $signed({4'b0000, u}) - $signed({4'b0000, d})
			- $signed({4'b0000, l}) - $signed({4'b0000, r});
		if (s[shp3_pkg::CH_W+3]) begin
			res = '0;
		end else if (s > $signed((shp3_pkg::CH_W+4)'(255))) begin
			res = '1;
		end else begin
			res = s[shp3_pkg::CH_W-1:0];
		end
		return res;
	endfunction

	// right and lower neighbors always sit in the newest column and row
	always_comb begin
		pc = win[kx][ky];
		pu = win[kx][ku];
		pd = win[kx][2'd2];
		pl = win[kl][ky];
		pr = win[2'd2][ky];
		red   = sharpen(pc[2*shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pu[2*shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pd[2*shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pl[2*shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pr[2*shp3_pkg::CH_W +: shp3_pkg::CH_W]);
		green = sharpen(pc[shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pu[shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pd[shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pl[shp3_pkg::CH_W +: shp3_pkg::CH_W],
			pr[shp3_pkg::CH_W +: shp3_pkg::CH_W]);
		blue  = sharpen(pc[0 +: shp3_pkg::CH_W],
			pu[0 +: shp3_pkg::CH_W],
			pd[0 +: shp3_pkg::CH_W],
			pl[0 +: shp3_pkg::CH_W],
			pr[0 +: shp3_pkg::CH_W]);
	end

endmodule

FILE: sv/shp3_window.sv
// 3x3 window, result sequencer and output register.
module shp3_window (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_s1,
	input  shp3_pkg::s1_t                     item_s1,
	output logic                              take,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [shp3_pkg::CH_W-1:0]         out_red,
	output logic [shp3_pkg::CH_W-1:0]         out_green,
	output logic [shp3_pkg::CH_W-1:0]         out_blue,
	output logic [shp3_pkg::COL_W-1:0]        out_column,
	output logic [shp3_pkg::ROW_W-1:0]        out_row,
	output logic                              last_of_run,
	output logic                              frame_done
);

	shp3_pkg::win_t              win_q;
	logic                        busy_q, selx_q, sely_q;
	logic [shp3_pkg::COL_W-1:0]  c_q;
	logic [shp3_pkg::ROW_W-1:0]  r_q;
	logic                        xl_q, xr_q, yu_q, yd_q, c1_q, r1_q;
	logic                        out_free, emit, has_next, item_emits;
	shp3_pkg::widx_t             kx, kl, ky, ku;
	logic [shp3_pkg::CH_W-1:0]   k_red, k_green, k_blue;

	assign out_free   = !out_valid || out_ready;
	assign emit       = busy_q && out_free;
	assign has_next   = (!selx_q && xr_q) || (!sely_q && yd_q);
	assign take       = v_s1 && (!busy_q || (emit && !has_next));
	assign item_emits = (item_s1.x_left || item_s1.x_right) && (item_s1.y_up || item_s1.y_down);

	// clamp the left and upper taps at the frame edge
	always_comb begin
		kx = selx_q ? 2'd2 : 2'd1;
		ky = sely_q ? 2'd2 : 2'd1;
		if (selx_q) begin
			kl = xl_q ? 2'd1 : 2'd2;
		end else begin
			kl = c1_q ? 2'd1 : 2'd0;
		end
		if (sely_q) begin
			ku = yu_q ? 2'd1 : 2'd2;
		end else begin
			ku = r1_q ? 2'd1 : 2'd0;
		end
	end

	shp3_kernel u_kernel (
		.win   (win_q),
		.kx    (kx),
		.kl    (kl),
		.ky    (ky),
		.ku    (ku),
		.red   (k_red),
		.green (k_green),
		.blue  (k_blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			busy_q    <= 1'b0;
			selx_q    <= 1'b0;
			sely_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= {item_s1.px, item_s1.middle, item_s1.upper};
				busy_q   <= item_emits;
				selx_q   <= !item_s1.x_left;
				sely_q   <= !item_s1.y_up;
			end else if (emit) begin
				if (has_next) begin
					if (!selx_q && xr_q) begin
						selx_q <= 1'b1;
					end else begin
						sely_q <= 1'b1;
						selx_q <= !xl_q;
					end
				end else begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			c_q  <= item_s1.col;
			r_q  <= item_s1.row;
			xl_q <= item_s1.x_left;
			xr_q <= item_s1.x_right;
			yu_q <= item_s1.y_up;
			yd_q <= item_s1.y_down;
			c1_q <= item_s1.col_is1;
			r1_q <= item_s1.row_is1;
		end
		if (emit) begin
			out_red     <= k_red;
			out_green   <= k_green;
			out_blue    <= k_blue;
			out_column  <= selx_q ? c_q : c_q - shp3_pkg::COL_W'(1);
			out_row     <= sely_q ? r_q : r_q - shp3_pkg::ROW_W'(1);
			last_of_run <= !has_next;
			frame_done  <= selx_q && sely_q;
		end
	end

endmodule

FILE: sv/shp3_checker.sv
// Port-level checks of the sharpening stream, bound to the top level.
module shp3_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [shp3_pkg::CH_W-1:0]         out_red,
	input  logic [shp3_pkg::CH_W-1:0]         out_green,
	input  logic [shp3_pkg::CH_W-1:0]         out_blue,
	input  logic [shp3_pkg::COL_W-1:0]        out_column,
	input  logic [shp3_pkg::ROW_W-1:0]        out_row,
	input  logic                              last_of_run,
	input  logic                              frame_done
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_column) && $stable(out_row)
			&& $stable(last_of_run) && $stable(frame_done))
		else $error("stalled output beat changed");

	// the frame's final pixel closes its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// a run continues without a gap once its beat is taken
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a result run");

	// within a run the next beat is the next column or the next row
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=>
			(out_row == $past(out_row)
				&& out_column == $past(out_column) + shp3_pkg::COL_W'(1))
			|| (out_row == $past(out_row) + shp3_pkg::ROW_W'(1)))
		else $error("result run out of raster order");

endmodule

bind sharpen_3x3_rgb_stream shp3_checker u_shp3_checker (.*);
